### rtl/rtp_receiver_statistics_assert.svh
// Assertion macros shared by the RTP receiver statistics RTL.
`ifndef RTP_RECEIVER_STATISTICS_ASSERT_SVH
`define RTP_RECEIVER_STATISTICS_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RTPRS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtprs assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RTPRS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtprs assertion failed");

`endif

### rtl/rtprs_pkg.sv
// Types and constants of the RTP receiver statistics block.
package rtprs_pkg;

   localparam int QueueDepth = 4;
   localparam int QueueIdxW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);
   localparam int CsrAddrW   = 4;

   localparam logic [1:0]  RtpVersion     = 2'd2;
   localparam logic [3:0]  NoCsrc         = 4'd0;
   localparam logic [23:0] ClockRateReset = 24'd90000;
   localparam logic [31:0] JitterRound    = 32'd8;
   localparam int          JitterShift    = 4;

   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_BAD_VERSION   = 3'd1,
      STATUS_CSRC_PRESENT  = 3'd2,
      STATUS_PT_MISMATCH   = 3'd3,
      STATUS_SSRC_MISMATCH = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      REG_PAYLOAD_TYPE = 2'd0,
      REG_CLOCK_RATE   = 2'd1,
      REG_SENDER_SSRC  = 2'd2,
      REG_START_TS     = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      BK_CLASSIFY = 2'd0,
      BK_SCALE    = 2'd1,
      BK_TRANSIT  = 2'd2,
      BK_UPDATE   = 2'd3
   } back_state_type;

   typedef struct packed {
      logic [6:0]  expected_pt;
      logic [23:0] clock_rate;
      logic [31:0] sender_ssrc;
      logic [31:0] start_ts;
   } cfg_type;

   // One classified header as it travels from front to back.
   typedef struct packed {
      status_type  status;     // OK here means the version, CSRC and payload type checks passed
      logic        ssrc_ok;
      logic        marker;
      logic [6:0]  pt;
      logic        padding;
      logic        extension;
      logic [15:0] seq;
      logic [31:0] ts;
      logic [31:0] sec;
      logic [23:0] frac_units;
   } entry_type;

endpackage

### rtl/rtp_receiver_statistics.sv
// Top level of the RTP receiver statistics block.
//
//  channel  direction  handshake              carries
//  req_     in         req_valid / req_stall  one RTP fixed header plus NTP arrival time
//  rsp_     out        rsp_valid / rsp_stall  status, decoded header, jitter, counters
//  APB      in/out     psel / penable         four configuration registers at 4*i
//
// The back end takes each header through classify, scale multiply, transit and
// update in turn, and takes no new header until it has loaded the last result.
// The front register and a 4-entry queue keep taking headers while the back works
// or while a finished result waits under rsp_stall.
// Reset is synchronous; it clears all counters and the jitter and loads the
// register defaults. There is no clearing pass.
module rtp_receiver_statistics import rtprs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // header input
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_header_word,
   input  logic [31:0]         req_media_timestamp,
   input  logic [31:0]         req_source_id,
   input  logic [31:0]         req_arrival_seconds,
   input  logic [31:0]         req_arrival_fraction,
   // statistics output
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic                rsp_marker_bit,
   output logic [6:0]          rsp_payload_kind,
   output logic                rsp_padding_bit,
   output logic                rsp_extension_bit,
   output logic [15:0]         rsp_sequence_number,
   output logic [31:0]         rsp_jitter_scaled,
   output logic [31:0]         rsp_packets_received,
   output logic [31:0]         rsp_packets_expected,
   output logic [31:0]         rsp_packets_lost,
   output logic [31:0]         rsp_sequence_cycles,
   output logic [31:0]         rsp_arrival_in_media_units,
   // configuration
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   cfg_type   cfg;
   entry_type front_entry, queue_head;
   logic      push, pop, q_full, q_empty;

   rtprs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // front: version, CSRC and payload type checks, fraction scaling
   rtprs_front u_front (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_header_word      (req_header_word),
      .req_media_timestamp  (req_media_timestamp),
      .req_source_id        (req_source_id),
      .req_arrival_seconds  (req_arrival_seconds),
      .req_arrival_fraction (req_arrival_fraction),
      .q_full               (q_full),
      .push                 (push),
      .entry                (front_entry)
   );

   rtprs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .head       (queue_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   // back: stateful checks, jitter and loss accounting, result register
   rtprs_back u_back (
      .clock                      (clock),
      .reset                      (reset),
      .cfg                        (cfg),
      .q_empty                    (q_empty),
      .head                       (queue_head),
      .pop                        (pop),
      .rsp_valid                  (rsp_valid),
      .rsp_stall                  (rsp_stall),
      .rsp_status                 (rsp_status),
      .rsp_marker_bit             (rsp_marker_bit),
      .rsp_payload_kind           (rsp_payload_kind),
      .rsp_padding_bit            (rsp_padding_bit),
      .rsp_extension_bit          (rsp_extension_bit),
      .rsp_sequence_number        (rsp_sequence_number),
      .rsp_jitter_scaled          (rsp_jitter_scaled),
      .rsp_packets_received       (rsp_packets_received),
      .rsp_packets_expected       (rsp_packets_expected),
      .rsp_packets_lost           (rsp_packets_lost),
      .rsp_sequence_cycles        (rsp_sequence_cycles),
      .rsp_arrival_in_media_units (rsp_arrival_in_media_units)
   );

endmodule

### rtl/rtprs_csr.sv
// Configuration registers behind the APB-style port.
module rtprs_csr import rtprs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output cfg_type             cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[CsrAddrW-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_PAYLOAD_TYPE: cfg_in.expected_pt = pwdata[6:0];
            REG_CLOCK_RATE:   cfg_in.clock_rate  = pwdata[23:0];
            REG_SENDER_SSRC:  cfg_in.sender_ssrc = pwdata;
            REG_START_TS:     cfg_in.start_ts    = pwdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_PAYLOAD_TYPE: prdata = {25'd0, cfg_ff.expected_pt};
         REG_CLOCK_RATE:   prdata = {8'd0, cfg_ff.clock_rate};
         REG_SENDER_SSRC:  prdata = cfg_ff.sender_ssrc;
         REG_START_TS:     prdata = cfg_ff.start_ts;
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_pt <= '0;
         cfg_ff.clock_rate  <= ClockRateReset;
         cfg_ff.sender_ssrc <= '0;
         cfg_ff.start_ts    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/rtprs_front.sv
// Front end: takes headers, checks the stateless fields, scales the fraction.
module rtprs_front import rtprs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_header_word,
   input  logic [31:0] req_media_timestamp,
   input  logic [31:0] req_source_id,
   input  logic [31:0] req_arrival_seconds,
   input  logic [31:0] req_arrival_fraction,
   input  logic        q_full,
   output logic        push,
   output entry_type   entry
);

   logic        valid_ff, valid_in;
   logic [31:0] hw_ff, ts_ff, ssrc_ff, sec_ff, frac_ff;
   logic        accept;
   logic [29:0] frac_prod;
   status_type  status;

   assign req_stall = valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !q_full;
   assign valid_in  = accept || (valid_ff && q_full);

   // top six fraction bits times the tick rate, in 1/64 ticks
   assign frac_prod = {24'd0, frac_ff[31:26]} * {6'd0, cfg.clock_rate};

   always_comb begin
      priority if (hw_ff[31:30] != RtpVersion)       status = STATUS_BAD_VERSION;
      else if (hw_ff[27:24] != NoCsrc)               status = STATUS_CSRC_PRESENT;
      else if (hw_ff[22:16] != cfg.expected_pt)      status = STATUS_PT_MISMATCH;
      else                                           status = STATUS_OK;
   end

   always_comb begin
      entry.status     = status;
      entry.ssrc_ok    = (cfg.sender_ssrc == '0) || (cfg.sender_ssrc == ssrc_ff);
      entry.marker     = hw_ff[23];
      entry.pt         = hw_ff[22:16];
      entry.padding    = hw_ff[29];
      entry.extension  = hw_ff[28];
      entry.seq        = hw_ff[15:0];
      entry.ts         = ts_ff;
      entry.sec        = sec_ff;
      entry.frac_units = frac_prod[29:6];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hw_ff   <= req_header_word;
         ts_ff   <= req_media_timestamp;
         ssrc_ff <= req_source_id;
         sec_ff  <= req_arrival_seconds;
         frac_ff <= req_arrival_fraction;
      end
   end

endmodule

### rtl/rtprs_queue.sv
// Small FIFO of classified headers between front and back.
`include "rtp_receiver_statistics_assert.svh"

module rtprs_queue import rtprs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);

   entry_type              mem_ff [QueueDepth];
   logic [QueueIdxW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueueIdxW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;

   function automatic logic [QueueIdxW-1:0] next_ptr(input logic [QueueIdxW-1:0] p);
      if (p == QueueIdxW'(QueueDepth - 1)) return '0;
      else return p + 1'b1;
   endfunction

   assign full  = (count_ff == QueueCntW'(QueueDepth));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   `RTPRS_ASSERT_IMP(a_no_overflow, clock, reset, push, !full)
   `RTPRS_ASSERT_IMP(a_no_underflow, clock, reset, pop, !empty)

endmodule

### rtl/rtprs_back.sv
// Back end: SSRC check, time scaling, jitter and sequence counters.
`include "rtp_receiver_statistics_assert.svh"

module rtprs_back import rtprs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_empty,
   input  entry_type   head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_marker_bit,
   output logic [6:0]  rsp_payload_kind,
   output logic        rsp_padding_bit,
   output logic        rsp_extension_bit,
   output logic [15:0] rsp_sequence_number,
   output logic [31:0] rsp_jitter_scaled,
   output logic [31:0] rsp_packets_received,
   output logic [31:0] rsp_packets_expected,
   output logic [31:0] rsp_packets_lost,
   output logic [31:0] rsp_sequence_cycles,
   output logic [31:0] rsp_arrival_in_media_units
);

   back_state_type state_ff, state_in;

   // stream state
   logic        time_base_set_ff, time_base_set_in;
   logic [31:0] base_seconds_ff, base_seconds_in;
   logic        start_known_ff, start_known_in;
   logic [15:0] last_seq_ff, last_seq_in;
   logic [31:0] last_transit_ff, last_transit_in;
   logic [31:0] jitter_ff, jitter_in;
   logic [31:0] received_ff, received_in;
   logic [31:0] expected_ff, expected_in;
   logic [31:0] lost_ff, lost_in;
   logic [31:0] wraps_ff, wraps_in;

   // item in flight
   entry_type   item_ff, item_in;
   status_type  status_ff, status_in;
   logic        first_ff, first_in;
   logic [31:0] diff_ff, diff_in;
   logic [31:0] arrival_ff, arrival_in;
   logic [31:0] delta_abs_ff, delta_abs_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic        load;
   status_type  out_status_ff;
   entry_type   out_item_ff;
   logic [31:0] out_jitter_ff, out_received_ff, out_expected_ff, out_lost_ff;
   logic [31:0] out_wraps_ff, out_arrival_ff;

   // helpers
   logic        pt_pass, item_ok;
   logic [55:0] scale_prod;
   logic [31:0] transit, delta, jitter_round;
   logic [15:0] eff_last, back_dist, fwd_dist;
   logic        out_reject, out_held;

   assign item_ok      = (status_ff == STATUS_OK);
   assign pt_pass      = (head.status == STATUS_OK);
   assign scale_prod   = {32'd0, cfg.clock_rate} * {24'd0, diff_ff};
   assign transit      = arrival_ff - item_ff.ts;
   assign delta        = transit - last_transit_ff;
   assign jitter_round = (jitter_ff + JitterRound) >> JitterShift;
   assign eff_last     = first_ff ? (item_ff.seq - 1'b1) : last_seq_ff;
   assign back_dist    = eff_last - item_ff.seq;
   assign fwd_dist     = item_ff.seq - eff_last;

   always_comb begin
      state_in         = state_ff;
      time_base_set_in = time_base_set_ff;
      base_seconds_in  = base_seconds_ff;
      start_known_in   = start_known_ff;
      last_seq_in      = last_seq_ff;
      last_transit_in  = last_transit_ff;
      jitter_in        = jitter_ff;
      received_in      = received_ff;
      expected_in      = expected_ff;
      lost_in          = lost_ff;
      wraps_in         = wraps_ff;
      item_in          = item_ff;
      status_in        = status_ff;
      first_in         = first_ff;
      diff_in          = diff_ff;
      arrival_in       = arrival_ff;
      delta_abs_in     = delta_abs_ff;
      pop              = 1'b0;
      load             = 1'b0;

      unique case (state_ff)
         BK_CLASSIFY: begin
            if (!q_empty) begin
               pop     = 1'b1;
               item_in = head;
               // start timestamp learning happens on a payload type pass, SSRC outcome aside
               if (pt_pass && (cfg.start_ts == '0) && !start_known_ff) begin
                  start_known_in = 1'b1;
                  wraps_in       = '0;
               end
               if (pt_pass && !time_base_set_ff && !head.ssrc_ok)
                  status_in = STATUS_SSRC_MISMATCH;
               else
                  status_in = head.status;
               first_in = pt_pass && head.ssrc_ok && !time_base_set_ff;
               if (pt_pass && (head.ssrc_ok || time_base_set_ff) && !time_base_set_ff) begin
                  time_base_set_in = 1'b1;
                  base_seconds_in  = head.sec;
               end
               diff_in  = time_base_set_ff ? (head.sec - base_seconds_ff) : '0;
               state_in = BK_SCALE;
            end
         end
         BK_SCALE: begin
            arrival_in = {8'd0, item_ff.frac_units} + scale_prod[31:0];
            state_in   = BK_TRANSIT;
         end
         BK_TRANSIT: begin
            delta_abs_in = delta[31] ? (32'd0 - delta) : delta;
            if (item_ok) last_transit_in = transit;
            state_in = BK_UPDATE;
         end
         BK_UPDATE: begin
            if (!out_valid_ff || !rsp_stall) begin
               load = 1'b1;
               if (item_ok) begin
                  if ((item_ff.seq < eff_last) && back_dist[15])
                     wraps_in = wraps_ff + 1'b1;
                  jitter_in = jitter_ff + delta_abs_ff - jitter_round;
                  received_in = received_ff + 1'b1;
                  if (fwd_dist == 16'd1) begin
                     expected_in = expected_ff + 1'b1;
                  end else if (fwd_dist != 16'd0) begin
                     expected_in = expected_ff + {16'd0, fwd_dist};
                     lost_in     = lost_ff + {16'd0, fwd_dist};
                  end
                  last_seq_in = item_ff.seq;
               end
               state_in = BK_CLASSIFY;
            end
         end
         default: state_in = BK_CLASSIFY;
      endcase
   end

   assign out_valid_in = load || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= BK_CLASSIFY;
         out_valid_ff     <= 1'b0;
         time_base_set_ff <= 1'b0;
         base_seconds_ff  <= '0;
         start_known_ff   <= 1'b0;
         last_seq_ff      <= '0;
         last_transit_ff  <= '0;
         jitter_ff        <= '0;
         received_ff      <= '0;
         expected_ff      <= '0;
         lost_ff          <= '0;
         wraps_ff         <= '0;
      end else begin
         state_ff         <= state_in;
         out_valid_ff     <= out_valid_in;
         time_base_set_ff <= time_base_set_in;
         base_seconds_ff  <= base_seconds_in;
         start_known_ff   <= start_known_in;
         last_seq_ff      <= last_seq_in;
         last_transit_ff  <= last_transit_in;
         jitter_ff        <= jitter_in;
         received_ff      <= received_in;
         expected_ff      <= expected_in;
         lost_ff          <= lost_in;
         wraps_ff         <= wraps_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      status_ff    <= status_in;
      first_ff     <= first_in;
      diff_ff      <= diff_in;
      arrival_ff   <= arrival_in;
      delta_abs_ff <= delta_abs_in;
      if (load) begin
         out_status_ff   <= status_ff;
         out_item_ff     <= item_ff;
         out_jitter_ff   <= jitter_in;
         out_received_ff <= received_in;
         out_expected_ff <= expected_in;
         out_lost_ff     <= lost_in;
         out_wraps_ff    <= wraps_in;
         out_arrival_ff  <= item_ok ? arrival_ff : '0;
      end
   end

   assign rsp_valid                  = out_valid_ff;
   assign rsp_status                 = out_status_ff;
   assign rsp_marker_bit             = out_item_ff.marker;
   assign rsp_payload_kind           = out_item_ff.pt;
   assign rsp_padding_bit            = out_item_ff.padding;
   assign rsp_extension_bit          = out_item_ff.extension;
   assign rsp_sequence_number        = out_item_ff.seq;
   assign rsp_jitter_scaled          = out_jitter_ff;
   assign rsp_packets_received       = out_received_ff;
   assign rsp_packets_expected       = out_expected_ff;
   assign rsp_packets_lost           = out_lost_ff;
   assign rsp_sequence_cycles        = out_wraps_ff;
   assign rsp_arrival_in_media_units = out_arrival_ff;

   assign out_reject = out_valid_ff && (out_status_ff != STATUS_OK);
   assign out_held   = (state_ff == BK_UPDATE) && out_valid_ff && rsp_stall;

   `RTPRS_ASSERT_IMP(a_reject_no_arrival, clock, reset, out_reject, out_arrival_ff == '0)
   `RTPRS_ASSERT_NXT(a_update_holds, clock, reset, out_held, state_ff == BK_UPDATE)

endmodule
